// ===== rtl/fmts_pkg.sv =====
// package for the four-motor throttle supervisor: codes, widths and the
// command and status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package fmts_pkg;

  localparam int OP_W        = 2;
  localparam int THR_W       = 16;
  localparam int CEIL_W      = 15;
  localparam int DUTY_W      = 13;
  localparam int STATE_W     = 3;
  localparam int FAULT_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int MOTOR_PORTS = 4;
  localparam int MOTOR_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_ESTOP     = 2'd1;
  localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd2;
  localparam logic [OP_W-1:0] OP_THROTTLE  = 2'd3;

  localparam logic [STATE_W-1:0] ST_INIT      = 3'd0;
  localparam logic [STATE_W-1:0] ST_IDLE      = 3'd1;
  localparam logic [STATE_W-1:0] ST_DRIVING   = 3'd2;
  localparam logic [STATE_W-1:0] ST_SAFE_STOP = 3'd3;
  localparam logic [STATE_W-1:0] ST_ESTOP     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 3'd4;

  typedef struct packed {
    logic                   capture;
    logic                   load;
    logic                   init;
    logic                   step;
    logic                   store;
    logic                   publish;
    logic [MOTOR_IDX_W-1:0] motor;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/fmts_ctrl.sv =====
// sequencer for the throttle supervisor: accepts an item, walks the four
// motors through load, divide and store, then publishes the result
// depends on fmts_pkg
`timescale 1ns / 1ps

module fmts_ctrl #(
  parameter int STEPS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fmts_pkg::dp_status_t  status,
  output fmts_pkg::ctrl_cmd_t   cmd
);

  localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_PUB   = 3'd5;

  logic [2:0]                       state, state_next;
  logic [fmts_pkg::MOTOR_IDX_W-1:0] motor, motor_next;
  logic [SW-1:0]                    cnt, cnt_next;

  always_comb begin
    state_next  = state;
    motor_next  = motor;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.motor   = motor;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          motor_next  = '0;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + SW'(1);
        if (cnt == SW'(STEPS - 1)) state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (motor == fmts_pkg::MOTOR_IDX_W'(fmts_pkg::MOTOR_PORTS - 1)) begin
          state_next = S_PUB;
        end else begin
          motor_next = motor + fmts_pkg::MOTOR_IDX_W'(1);
          state_next = S_LOAD;
        end
      end
      S_PUB: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      motor <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      motor <= motor_next;
      cnt   <= cnt_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== rtl/fmts_datapath.sv =====
// datapath for the throttle supervisor: configuration, supervisor state,
// per-motor clamp and deadband, serial duty divider and output register
// depends on fmts_pkg
`timescale 1ns / 1ps

module fmts_datapath #(
  parameter int MOTOR_COUNT     = 4,
  parameter int DUTY_FULL_SCALE = 4095
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  fmts_pkg::ctrl_cmd_t                     cmd,
  output fmts_pkg::dp_status_t                    status,
  input  logic                                    cfg_write_enable,
  input  logic [fmts_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [fmts_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic [fmts_pkg::OP_W-1:0]               op,
  input  logic                                    heartbeat_estop,
  input  logic signed [fmts_pkg::THR_W-1:0]       throttle_front_left,
  input  logic signed [fmts_pkg::THR_W-1:0]       throttle_front_right,
  input  logic signed [fmts_pkg::THR_W-1:0]       throttle_rear_left,
  input  logic signed [fmts_pkg::THR_W-1:0]       throttle_rear_right,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [fmts_pkg::STATE_W-1:0]            supervisor_state,
  output logic [fmts_pkg::FAULT_W-1:0]            fault_flags,
  output logic                                    motor_enable,
  output logic signed [fmts_pkg::DUTY_W-1:0]      duty_front_left,
  output logic signed [fmts_pkg::DUTY_W-1:0]      duty_front_right,
  output logic signed [fmts_pkg::DUTY_W-1:0]      duty_rear_left,
  output logic signed [fmts_pkg::DUTY_W-1:0]      duty_rear_right,
  output logic signed [fmts_pkg::THR_W-1:0]       average_left,
  output logic signed [fmts_pkg::THR_W-1:0]       average_right
);

  localparam int TW  = fmts_pkg::THR_W;
  localparam int CW  = fmts_pkg::CEIL_W;
  localparam int DW  = fmts_pkg::DUTY_W;
  localparam int NP  = fmts_pkg::MOTOR_PORTS;
  localparam int QW  = $clog2(DUTY_FULL_SCALE + 1);
  localparam int PW  = TW + QW;
  localparam logic [QW-1:0] FS = QW'(DUTY_FULL_SCALE);

  // configuration
  logic [CW-1:0]        ceiling;
  logic signed [TW-1:0] floor_val;
  logic [CW-1:0]        dead_zone;
  logic [TW-1:0]        timeout;
  logic [NP-1:0]        invert;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling   <= CW'(1000);
      floor_val <= -16'sd1000;
      dead_zone <= CW'(50);
      timeout   <= TW'(500);
      invert    <= 4'b1010;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        fmts_pkg::REG_CEILING: ceiling   <= cfg_data[CW-1:0];
        fmts_pkg::REG_FLOOR:   floor_val <= $signed(cfg_data[TW-1:0]);
        fmts_pkg::REG_DEAD:    dead_zone <= cfg_data[CW-1:0];
        fmts_pkg::REG_TIMEOUT: timeout   <= cfg_data[TW-1:0];
        fmts_pkg::REG_INVERT:  invert    <= cfg_data[NP-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [TW-1:0] clamp_cmd(
    input logic signed [TW:0]   v,
    input logic [CW-1:0]        ceil_v,
    input logic signed [TW-1:0] floor_v
  );
    logic signed [TW:0] r;
    r = v;
    if (v > $signed({2'b00, ceil_v})) r = $signed({2'b00, ceil_v});
    else if (v < $signed({floor_v[TW-1], floor_v})) r = {floor_v[TW-1], floor_v};
    return r[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] mag16(input logic signed [TW-1:0] v);
    return v[TW-1] ? (~v + TW'(1)) : v;
  endfunction

  // supervisor state
  logic                 estop_latch;
  logic                 hb_seen;
  logic [TW-1:0]        ms_since;
  logic signed [TW-1:0] cmd_q [MOTOR_COUNT];
  logic signed [TW-1:0] thr_in [NP];
  logic signed [TW-1:0] cmd4 [NP];

  assign thr_in[0] = throttle_front_left;
  assign thr_in[1] = throttle_front_right;
  assign thr_in[2] = throttle_rear_left;
  assign thr_in[3] = throttle_rear_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      estop_latch <= 1'b0;
      hb_seen     <= 1'b0;
      ms_since    <= '0;
    end else if (cmd.capture) begin
      unique case (op)
        fmts_pkg::OP_TICK: begin
          if (ms_since != '1) ms_since <= ms_since + TW'(1);
        end
        fmts_pkg::OP_ESTOP: estop_latch <= 1'b1;
        fmts_pkg::OP_HEARTBEAT: begin
          ms_since    <= '0;
          hb_seen     <= 1'b1;
          estop_latch <= heartbeat_estop;
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_store
    always_ff @(posedge clk) begin
      if (rst) begin
        cmd_q[g] <= '0;
      end else if (cmd.capture && op == fmts_pkg::OP_THROTTLE) begin
        if (g < NP) cmd_q[g] <= clamp_cmd({thr_in[g % NP][TW-1], thr_in[g % NP]},
                                          ceiling, floor_val);
        else cmd_q[g] <= '0;
      end
    end
  end

  for (genvar g = 0; g < NP; g++) begin : g_view
    if (g < MOTOR_COUNT) begin : g_real
      assign cmd4[g] = cmd_q[g];
    end else begin : g_none
      assign cmd4[g] = '0;
    end
  end

  logic lost, armed, moving;
  logic [fmts_pkg::STATE_W-1:0] st;
  logic [fmts_pkg::FAULT_W-1:0] faults;

  assign lost  = (ms_since >= timeout);
  assign armed = hb_seen && !lost && !estop_latch;

  always_comb begin
    moving = 1'b0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (mag16(cmd_q[i]) >= {1'b0, dead_zone}) moving = 1'b1;
    end
    faults = '0;
    if (estop_latch) begin
      st        = fmts_pkg::ST_ESTOP;
      faults[0] = 1'b1;
    end else if (!hb_seen) begin
      st = fmts_pkg::ST_INIT;
    end else if (lost) begin
      st        = fmts_pkg::ST_SAFE_STOP;
      faults[1] = 1'b1;
    end else begin
      st = moving ? fmts_pkg::ST_DRIVING : fmts_pkg::ST_IDLE;
    end
  end

  // per-motor load: invert, clamp, deadband, scale
  logic signed [TW:0]   c_raw;
  logic signed [TW-1:0] c_clamp;
  logic [TW-1:0]        c_mag;
  logic [PW-1:0]        prod;
  logic                 neg, zero;

  always_comb begin
    c_raw = {cmd4[cmd.motor][TW-1], cmd4[cmd.motor]};
    if (invert[cmd.motor]) c_raw = -c_raw;
    c_clamp = clamp_cmd(c_raw, ceiling, floor_val);
    c_mag   = mag16(c_clamp);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod <= PW'(c_mag) * PW'(DUTY_FULL_SCALE);
      neg  <= c_clamp[TW-1];
      zero <= !armed || (c_mag == '0) || (c_mag < {1'b0, dead_zone})
              || (int'(cmd.motor) >= MOTOR_COUNT);
    end
  end

  // restoring divider, one quotient bit per step
  logic [TW-1:0] rem;
  logic [QW-1:0] plow;
  logic [QW-1:0] quo;
  logic          sat;
  logic [TW-1:0] trial;
  logic          fits;

  assign trial = {rem[TW-2:0], plow[QW-1]};
  assign fits  = (trial >= {1'b0, ceiling});

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      rem  <= prod[PW-1:QW];
      plow <= prod[QW-1:0];
      quo  <= '0;
      sat  <= (prod >= {1'b0, ceiling, QW'(0)});
    end else if (cmd.step) begin
      rem  <= fits ? (trial - {1'b0, ceiling}) : trial;
      plow <= plow << 1;
      quo  <= {quo[QW-2:0], fits};
    end
  end

  logic [QW-1:0]        dmag;
  logic signed [QW:0]   dsgn;
  logic signed [DW-1:0] dtrunc;
  logic signed [DW-1:0] duty_q [NP];

  always_comb begin
    dmag = (sat || quo > FS) ? FS : quo;
    if (zero) dsgn = '0;
    else if (neg) dsgn = -$signed({1'b0, dmag});
    else dsgn = $signed({1'b0, dmag});
  end

  if (QW + 1 >= DW) begin : g_trunc
    assign dtrunc = dsgn[DW-1:0];
  end else begin : g_ext
    assign dtrunc = {{(DW - QW - 1){dsgn[QW]}}, dsgn};
  end

  always_ff @(posedge clk) begin
    if (cmd.store) duty_q[cmd.motor] <= dtrunc;
  end

  // averages, truncated toward zero
  logic signed [TW:0] sum_l, sum_r, adj_l, adj_r;

  always_comb begin
    sum_l = {cmd4[0][TW-1], cmd4[0]} + {cmd4[2][TW-1], cmd4[2]};
    sum_r = {cmd4[1][TW-1], cmd4[1]} + {cmd4[3][TW-1], cmd4[3]};
    adj_l = sum_l + (TW+1)'(sum_l[TW]);
    adj_r = sum_r + (TW+1)'(sum_r[TW]);
  end

  // output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      supervisor_state <= st;
      fault_flags      <= faults;
      motor_enable     <= armed;
      duty_front_left  <= duty_q[0];
      duty_front_right <= duty_q[1];
      duty_rear_left   <= duty_q[2];
      duty_rear_right  <= duty_q[3];
      average_left     <= adj_l[TW:1];
      average_right    <= adj_r[TW:1];
    end
  end

`ifndef SYNTHESIS
  a_disarmed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !motor_enable |-> duty_front_left == '0 && duty_front_right == '0
      && duty_rear_left == '0 && duty_rear_right == '0)
    else $error("duty nonzero while disarmed");

  a_estop_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fault_flags[0] == (supervisor_state == fmts_pkg::ST_ESTOP))
    else $error("estop fault bit disagrees with state");

  a_enable_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_enable |-> supervisor_state == fmts_pkg::ST_DRIVING
      || supervisor_state == fmts_pkg::ST_IDLE)
    else $error("enabled outside idle or driving");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> status.out_free)
    else $error("result published over a waiting item");
`endif

endmodule

// ===== rtl/four_motor_throttle_safety_supervisor_core.sv =====
// four-motor throttle safety supervisor, top level
// the serial duty divider gives one quotient bit per cycle, for each motor in turn; a new
// item is taken the cycle after the result is published, even while that result waits;
// a stalled result delays the next publish
// reset: synchronous, clears latch, heartbeat state, stored commands, loads defaults
`timescale 1ns / 1ps

module four_motor_throttle_safety_supervisor_core #(
  parameter int MOTOR_COUNT     = 4,
  parameter int DUTY_FULL_SCALE = 4095
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [fmts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fmts_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fmts_pkg::OP_W-1:0]           op,
  input  logic                                heartbeat_estop,
  input  logic signed [fmts_pkg::THR_W-1:0]   throttle_front_left,
  input  logic signed [fmts_pkg::THR_W-1:0]   throttle_front_right,
  input  logic signed [fmts_pkg::THR_W-1:0]   throttle_rear_left,
  input  logic signed [fmts_pkg::THR_W-1:0]   throttle_rear_right,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fmts_pkg::STATE_W-1:0]        supervisor_state,
  output logic [fmts_pkg::FAULT_W-1:0]        fault_flags,
  output logic                                motor_enable,
  output logic signed [fmts_pkg::DUTY_W-1:0]  duty_front_left,
  output logic signed [fmts_pkg::DUTY_W-1:0]  duty_front_right,
  output logic signed [fmts_pkg::DUTY_W-1:0]  duty_rear_left,
  output logic signed [fmts_pkg::DUTY_W-1:0]  duty_rear_right,
  output logic signed [fmts_pkg::THR_W-1:0]   average_left,
  output logic signed [fmts_pkg::THR_W-1:0]   average_right
);

  fmts_pkg::ctrl_cmd_t  cmd;
  fmts_pkg::dp_status_t status;

  fmts_ctrl #(
    .STEPS ($clog2(DUTY_FULL_SCALE + 1))
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fmts_datapath #(
    .MOTOR_COUNT     (MOTOR_COUNT),
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .cfg_write_enable     (cfg_write_enable),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .op                   (op),
    .heartbeat_estop      (heartbeat_estop),
    .throttle_front_left  (throttle_front_left),
    .throttle_front_right (throttle_front_right),
    .throttle_rear_left   (throttle_rear_left),
    .throttle_rear_right  (throttle_rear_right),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .supervisor_state     (supervisor_state),
    .fault_flags          (fault_flags),
    .motor_enable         (motor_enable),
    .duty_front_left      (duty_front_left),
    .duty_front_right     (duty_front_right),
    .duty_rear_left       (duty_rear_left),
    .duty_rear_right      (duty_rear_right),
    .average_left         (average_left),
    .average_right        (average_right)
  );

endmodule
